/* sv/ffra_pkg.sv */
// ffra_pkg: shared types, codes and helpers for the first-fit range allocator
// used by ffra_ctrl, ffra_dp and first_fit_range_allocator_core; no dependencies
`default_nettype none

package ffra_pkg;

    typedef logic [15:0] start_t;
    typedef logic [16:0] size_t;

    typedef struct packed {
        start_t start;
        size_t  size;
    } range_t;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // pointer operations
    localparam logic [2:0] PTR_HOLD = 3'd0;
    localparam logic [2:0] PTR_ZERO = 3'd1;
    localparam logic [2:0] PTR_INC  = 3'd2;
    localparam logic [2:0] PTR_DEC  = 3'd3;
    localparam logic [2:0] PTR_USED = 3'd4;
    localparam logic [2:0] PTR_RDI1 = 3'd5;
    localparam logic [2:0] PTR_POS1 = 3'd6;

    // read address select
    localparam logic RD_PTR    = 1'b0;
    localparam logic RD_PTR_M1 = 1'b1;

    // write select
    localparam logic [2:0] WR_INIT  = 3'd0;
    localparam logic [2:0] WR_ALLOC = 3'd1;
    localparam logic [2:0] WR_MERGE = 3'd2;
    localparam logic [2:0] WR_UP    = 3'd3;
    localparam logic [2:0] WR_DN    = 3'd4;
    localparam logic [2:0] WR_NEW   = 3'd5;

    // insert position operations
    localparam logic [1:0] POS_HOLD = 2'd0;
    localparam logic [1:0] POS_RDI  = 2'd1;
    localparam logic [1:0] POS_USED = 2'd2;

    typedef struct packed {
        logic       init_wr;
        logic       load_item;
        logic [2:0] ptr_op;
        logic       rd_en;
        logic       rd_sel;
        logic       wr_en;
        logic [2:0] wr_sel;
        logic [1:0] pos_op;
        logic       prev_we;
        logic       lat_next;
        logic       used_inc;
        logic       used_dec;
        logic       st_we;
        logic [1:0] st_code;
        logic       idx_we;
        logic       res_load;
    } cmd_t;

    typedef struct packed {
        logic init_pending;
        logic is_free;
        logic len_zero;
        logic table_full;
        logic rd_vld;
        logic hit;
        logic ptr_lt_used;
        logic ptr_gt_pos;
        logic new_size_zero;
        logic touch_next;
        logic touch_prev;
        logic out_free;
    } stat_t;

    // clamp an 18-bit sum to the largest size
    function automatic size_t sat_size(input logic [17:0] v);
        sat_size = v[17] ? '1 : v[16:0];
    endfunction

endpackage

`default_nettype wire

/* sv/ffra_ctrl.sv */
// ffra_ctrl: sequencing state machine for the range allocator
// depends on ffra_pkg for command and status structs
`default_nettype none

module ffra_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire ffra_pkg::stat_t st,
    output ffra_pkg::cmd_t      cmd
);
    import ffra_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SHUP   = 3'd4;
    localparam logic [2:0] S_SHDN   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (st.init_pending) begin
                    state_next = S_INIT;
                end else begin
                    s_tready = 1'b1;
                    if (s_tvalid) begin
                        cmd.load_item = 1'b1;
                        cmd.ptr_op    = PTR_ZERO;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_INIT: begin
                cmd.init_wr = 1'b1;
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_INIT;
                state_next  = S_IDLE;
            end
            S_SCAN: begin
                if (st.is_free && st.len_zero) begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = ST_OK;
                    state_next  = S_DONE;
                end else if (st.is_free && st.table_full) begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = ST_FULL;
                    state_next  = S_DONE;
                end else if (st.rd_vld && st.hit) begin
                    if (!st.is_free) begin
                        cmd.idx_we  = 1'b1;
                        cmd.st_we   = 1'b1;
                        cmd.st_code = ST_OK;
                        if (st.new_size_zero) begin
                            cmd.ptr_op = PTR_RDI1;
                            state_next = S_SHDN;
                        end else begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WR_ALLOC;
                            state_next = S_DONE;
                        end
                    end else begin
                        cmd.pos_op   = POS_RDI;
                        cmd.lat_next = 1'b1;
                        state_next   = S_DECIDE;
                    end
                end else if (!st.rd_vld && !st.ptr_lt_used) begin
                    if (!st.is_free) begin
                        cmd.st_we   = 1'b1;
                        cmd.st_code = ST_NOSPACE;
                        state_next  = S_DONE;
                    end else begin
                        cmd.pos_op = POS_USED;
                        state_next = S_DECIDE;
                    end
                end else begin
                    cmd.prev_we = st.rd_vld;
                    if (st.ptr_lt_used) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_PTR;
                        cmd.ptr_op = PTR_INC;
                    end
                end
            end
            S_DECIDE: begin
                cmd.st_we   = 1'b1;
                cmd.st_code = ST_OK;
                if (!st.touch_prev && !st.touch_next) begin
                    cmd.ptr_op = PTR_USED;
                    state_next = S_SHUP;
                end else if (st.touch_prev && st.touch_next) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_MERGE;
                    cmd.ptr_op = PTR_POS1;
                    state_next = S_SHDN;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_MERGE;
                    state_next = S_DONE;
                end
            end
            S_SHUP: begin
                if (st.rd_vld) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_UP;
                end
                if (st.ptr_gt_pos) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR_M1;
                    cmd.ptr_op = PTR_DEC;
                end else if (!st.rd_vld) begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = WR_NEW;
                    cmd.used_inc = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_SHDN: begin
                if (st.rd_vld) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_DN;
                end
                if (st.ptr_lt_used) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR;
                    cmd.ptr_op = PTR_INC;
                end else if (!st.rd_vld) begin
                    cmd.used_dec = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/ffra_dp.sv */
// ffra_dp: range table memory, scan pointers, merge arithmetic and result register
// depends on ffra_pkg; driven by ffra_ctrl commands
`default_nettype none

module ffra_dp #(
    parameter int MAX_RANGES = 64,
    parameter int MAX_SLOTS  = 65536
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire ffra_pkg::cmd_t cmd,
    output ffra_pkg::stat_t     st,
    input  wire logic           cfg_we,
    input  wire logic [16:0]    cfg_wdata,
    input  wire logic [39:0]    s_tdata,
    input  wire logic [0:0]     s_tuser,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [23:0]         m_tdata
);
    import ffra_pkg::*;

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] FullCount = CW'(MAX_RANGES);
    localparam logic [24:0]   MaxSlotsW = 25'(MAX_SLOTS);

    range_t mem [MAX_RANGES];

    logic [16:0]   cap_reg;
    logic          pend_reg;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] pos_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    range_t        rdata_reg;
    logic          func_reg;
    start_t        first_reg;
    size_t         len_reg;
    range_t        prev_reg;
    logic          has_prev_reg;
    range_t        next_reg;
    logic          has_next_reg;
    logic [1:0]    res_status_reg;
    start_t        res_index_reg;
    logic          m_valid_reg;
    logic [1:0]    m_status_reg;
    start_t        m_index_reg;

    logic [CW-1:0] ptr_m1;
    logic [CW-1:0] ptr_next;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    range_t        wdata;
    size_t         init_size;
    size_t         sum_next;
    size_t         sum_prev;
    logic          touch_next;
    logic          touch_prev;

    assign ptr_m1 = ptr_reg - CW'(1);
    assign raddr  = (cmd.rd_sel == RD_PTR_M1) ? ptr_m1[AW-1:0] : ptr_reg[AW-1:0];

    // capacity clamped to the managed slot count
    assign init_size = (25'(cap_reg) > MaxSlotsW) ? MaxSlotsW[16:0] : cap_reg;

    // merge arithmetic, touch test without wrap
    assign sum_next   = sat_size({1'b0, len_reg} + {1'b0, next_reg.size});
    assign touch_next = has_next_reg &&
                        (({2'b0, first_reg} + {1'b0, len_reg}) == {2'b0, next_reg.start});
    assign touch_prev = has_prev_reg &&
                        (({2'b0, prev_reg.start} + {1'b0, prev_reg.size}) == {2'b0, first_reg});
    assign sum_prev   = sat_size({1'b0, prev_reg.size} +
                                 {1'b0, (touch_next ? sum_next : len_reg)});

    always_comb begin
        waddr = rd_idx_reg;
        wdata = rdata_reg;
        case (cmd.wr_sel)
            WR_INIT: begin
                waddr = '0;
                wdata = '{start: '0, size: init_size};
            end
            WR_ALLOC: begin
                waddr = rd_idx_reg;
                wdata = '{start: rdata_reg.start + len_reg[15:0],
                          size:  rdata_reg.size - len_reg};
            end
            WR_MERGE: begin
                if (touch_prev) begin
                    waddr = pos_reg[AW-1:0] - AW'(1);
                    wdata = '{start: prev_reg.start, size: sum_prev};
                end else begin
                    waddr = pos_reg[AW-1:0];
                    wdata = '{start: first_reg, size: sum_next};
                end
            end
            WR_UP: begin
                waddr = rd_idx_reg + AW'(1);
                wdata = rdata_reg;
            end
            WR_DN: begin
                waddr = rd_idx_reg - AW'(1);
                wdata = rdata_reg;
            end
            WR_NEW: begin
                waddr = pos_reg[AW-1:0];
                wdata = '{start: first_reg, size: len_reg};
            end
            default: begin
                waddr = rd_idx_reg;
                wdata = rdata_reg;
            end
        endcase
    end

    // table memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb begin
        case (cmd.ptr_op)
            PTR_ZERO: ptr_next = '0;
            PTR_INC:  ptr_next = ptr_reg + CW'(1);
            PTR_DEC:  ptr_next = ptr_m1;
            PTR_USED: ptr_next = used_reg;
            PTR_RDI1: ptr_next = CW'(rd_idx_reg) + CW'(1);
            PTR_POS1: ptr_next = pos_reg + CW'(1);
            default:  ptr_next = ptr_reg;
        endcase
    end

    // pointers and item fields
    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (cmd.rd_en) begin
            rd_idx_reg <= raddr;
        end
        case (cmd.pos_op)
            POS_RDI:  pos_reg <= CW'(rd_idx_reg);
            POS_USED: pos_reg <= used_reg;
            default:  pos_reg <= pos_reg;
        endcase
        if (cmd.load_item) begin
            func_reg  <= s_tuser[0];
            first_reg <= s_tdata[15:0];
            len_reg   <= s_tdata[32:16];
        end
        if (cmd.prev_we) begin
            prev_reg <= rdata_reg;
        end
        if (cmd.lat_next) begin
            next_reg <= rdata_reg;
        end
        if (cmd.idx_we) begin
            res_index_reg <= rdata_reg.start;
        end else if (cmd.load_item) begin
            res_index_reg <= '0;
        end
        if (cmd.st_we) begin
            res_status_reg <= cmd.st_code;
        end else if (cmd.load_item) begin
            res_status_reg <= ST_OK;
        end
        if (cmd.res_load) begin
            m_index_reg  <= res_index_reg;
            m_status_reg <= res_status_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= 17'h10000;
            pend_reg     <= 1'b1;
            used_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            has_prev_reg <= 1'b0;
            has_next_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg  <= cfg_wdata;
                pend_reg <= 1'b1;
            end else if (cmd.init_wr) begin
                pend_reg <= 1'b0;
            end
            if (cmd.init_wr) begin
                used_reg <= (init_size == '0) ? '0 : CW'(1);
            end else if (cmd.used_inc) begin
                used_reg <= used_reg + CW'(1);
            end else if (cmd.used_dec) begin
                used_reg <= used_reg - CW'(1);
            end
            rd_vld_reg <= cmd.rd_en;
            if (cmd.load_item) begin
                has_prev_reg <= 1'b0;
            end else if (cmd.prev_we) begin
                has_prev_reg <= 1'b1;
            end
            if (cmd.load_item) begin
                has_next_reg <= 1'b0;
            end else if (cmd.lat_next) begin
                has_next_reg <= 1'b1;
            end
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        st.init_pending  = pend_reg;
        st.is_free       = func_reg;
        st.len_zero      = (len_reg == '0);
        st.table_full    = (used_reg == FullCount);
        st.rd_vld        = rd_vld_reg;
        st.hit           = func_reg ? (rdata_reg.start >= first_reg)
                                    : (rdata_reg.size >= len_reg);
        st.ptr_lt_used   = (ptr_reg < used_reg);
        st.ptr_gt_pos    = (ptr_reg > pos_reg);
        st.new_size_zero = (rdata_reg.size == len_reg);
        st.touch_next    = touch_next;
        st.touch_prev    = touch_prev;
        st.out_free      = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_status_reg, m_index_reg};

endmodule

`default_nettype wire

/* sv/first_fit_range_allocator_core.sv */
// first_fit_range_allocator_core: one item at a time; each word is served by a walk of the
// single-port table (scan up to the hit, then shift the rest of the table by one), and a
// new word is taken only after the result of the last one is loaded, so a result stall holds
// off the next word; the result waits in an output register; reset (aresetn low,
// synchronous) and every capacity write rebuild the table before the next input word is
// taken; depends on ffra_pkg, ffra_ctrl, ffra_dp
`default_nettype none

module first_fit_range_allocator_core #(
    parameter int MAX_RANGES = 64,
    parameter int MAX_SLOTS  = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // capacity register write
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_wdata,
    // request words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // first_index [15:0], run_length [32:16], zero pad
    input  wire logic [0:0]  s_tuser,   // func [0]: 0 allocate, 1 free
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // alloc_index [15:0], status [17:16], zero pad
);
    import ffra_pkg::*;

    // controller and datapath talk only through these two structs
    cmd_t  cmd;
    stat_t st;

    // state machine: idle, table rebuild, scan, merge decision, shifts, result hand-off
    ffra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // range table memory plus the arithmetic for first-fit and coalescing
    ffra_dp #(
        .MAX_RANGES (MAX_RANGES),
        .MAX_SLOTS  (MAX_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // a word just taken cannot already have its result loaded
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !cmd.res_load)
        else $error("result loaded the cycle after a word was taken");

    // a result load always shows up on the output
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |=> m_tvalid)
        else $error("loaded result not presented");

    // an insert never grows a full table
    a_no_grow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.used_inc |-> !st.table_full)
        else $error("range inserted into a full table");

    // a capacity write always schedules a table rebuild
    a_cfg_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> st.init_pending)
        else $error("capacity write did not request a rebuild");

endmodule

`default_nettype wire

/* test/ffra_tb_pkg.sv */
`timescale 1ns / 100ps
// ffra_tb_pkg: request codes shared by the allocator testbench top and its checker
// no dependencies

package ffra_tb_pkg;

    // func field of a request word
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

endpackage

/* test/ffra_result_checker.sv */
`timescale 1ns / 100ps
// ffra_result_checker: keeps its own copy of the free-range table, predicts every result
// word of the allocator and compares it; depends on ffra_pkg and ffra_tb_pkg

module ffra_result_checker #(
    parameter int MAX_RANGES = 64,
    parameter int MAX_SLOTS  = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        run_done,
    output int unsigned mismatches
);
    import ffra_pkg::*;
    import ffra_tb_pkg::*;

    localparam size_t CAPACITY_AT_RESET = 17'h10000;
    localparam int    PRINT_LIMIT       = 40;

    typedef struct {
        start_t      index;
        logic [1:0]  status;
        int unsigned seq;
    } grant_t;

    start_t      free_base [MAX_RANGES];
    size_t       free_len  [MAX_RANGES];
    int unsigned free_ranges = 0;
    size_t       slot_capacity = CAPACITY_AT_RESET;
    grant_t      expected_grants [$];
    int unsigned words_in = 0;
    int unsigned words_out = 0;
    int unsigned mismatch_count = 0;
    bit          leftovers_checked = 1'b0;

    assign mismatches = mismatch_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t ns mismatch: %s", $time, what);
        end
    endtask

    function automatic size_t clamp_len(input int unsigned v);
        return (v > 32'h1FFFF) ? 17'h1FFFF : v[16:0];
    endfunction

    function automatic void rebuild_table();
        int unsigned k;
        int unsigned cap;
        for (k = 0; k < MAX_RANGES; k++) begin
            free_base[k] = '0;
            free_len[k]  = '0;
        end
        cap = 32'(slot_capacity);
        if (cap > MAX_SLOTS) cap = MAX_SLOTS;
        if (cap == 0) begin
            free_ranges = 0;
        end else begin
            free_len[0] = clamp_len(cap);
            free_ranges = 1;
        end
    endfunction

    function automatic void drop_range(input int unsigned at);
        int unsigned k;
        for (k = at; k + 1 < free_ranges; k++) begin
            free_base[k] = free_base[k + 1];
            free_len[k]  = free_len[k + 1];
        end
        free_ranges--;
        free_base[free_ranges] = '0;
        free_len[free_ranges]  = '0;
    endfunction

    function automatic grant_t predict_grant(input logic op, input start_t first,
                                             input size_t count);
        grant_t      g;
        int unsigned pos;
        int unsigned k;
        int unsigned reach;
        bit          taken;
        g.index  = '0;
        g.status = ST_OK;
        g.seq    = words_in;
        if (op == FN_ALLOC) begin
            // first fit, shrink from the front
            taken = 1'b0;
            for (k = 0; k < free_ranges && !taken; k++) begin
                if (free_len[k] >= count) begin
                    g.index      = free_base[k];
                    free_base[k] = free_base[k] + count[15:0];
                    free_len[k]  = free_len[k] - count;
                    if (free_len[k] == '0) drop_range(k);
                    taken = 1'b1;
                end
            end
            if (!taken) g.status = ST_NOSPACE;
        end else if (count != '0) begin
            if (free_ranges >= MAX_RANGES) begin
                g.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < free_ranges && free_base[pos] < first) pos++;
                for (k = free_ranges; k > pos; k--) begin
                    free_base[k] = free_base[k - 1];
                    free_len[k]  = free_len[k - 1];
                end
                free_base[pos] = first;
                free_len[pos]  = count;
                free_ranges++;
                // coalesce with the following range, then with the one before
                if (pos + 1 < free_ranges) begin
                    reach = 32'(free_base[pos]) + 32'(free_len[pos]);
                    if (reach == 32'(free_base[pos + 1])) begin
                        free_len[pos] = clamp_len(32'(free_len[pos]) + 32'(free_len[pos + 1]));
                        drop_range(pos + 1);
                    end
                end
                if (pos > 0) begin
                    reach = 32'(free_base[pos - 1]) + 32'(free_len[pos - 1]);
                    if (reach == 32'(free_base[pos])) begin
                        free_len[pos - 1] = clamp_len(32'(free_len[pos - 1]) +
                                                      32'(free_len[pos]));
                        drop_range(pos);
                    end
                end
            end
        end
        return g;
    endfunction

    always @(posedge aclk) begin : watch
        grant_t want;
        if (!aresetn) begin
            slot_capacity = CAPACITY_AT_RESET;
            rebuild_table();
            expected_grants.delete();
        end else begin
            if (cfg_we) begin
                slot_capacity = cfg_wdata;
                rebuild_table();
            end
            if (s_tvalid && s_tready) begin
                expected_grants.insert(expected_grants.size(),
                                       predict_grant(s_tuser[0], s_tdata[15:0],
                                                     s_tdata[32:16]));
                words_in++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                              words_out));
                end else begin
                    want = expected_grants.pop_front();
                    if (m_tdata[17:16] != want.status)
                        report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                                  want.seq, m_tdata[17:16], want.status));
                    if (m_tdata[15:0] != want.index)
                        report_mismatch($sformatf("word %0d alloc_index %0d, expected %0d",
                                                  want.seq, m_tdata[15:0], want.index));
                    if (m_tdata[23:18] != '0)
                        report_mismatch($sformatf("word %0d pad bits %h not zero",
                                                  want.seq, m_tdata[23:18]));
                end
                words_out++;
            end
            if (run_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (expected_grants.size() != 0)
                    report_mismatch($sformatf("%0d expected result words never arrived",
                                              expected_grants.size()));
            end
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// testbench: drives request words and capacity writes into first_fit_range_allocator_core
// and gives the verdict from ffra_result_checker; depends on ffra_pkg, ffra_tb_pkg, the rtl

module testbench;
    import ffra_pkg::*;
    import ffra_tb_pkg::*;

    localparam int RANGES          = 64;
    localparam int SLOTS           = 65536;
    // settle margin after the last result, sized to outlast the worst table walk
    localparam int SETTLE_CYCLES   = 150;
    // longest honest quiet spell is the receiver hold-off plus one walk
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;

    // a run handed out by the block, kept so that it can be given back later
    typedef struct {
        start_t base;
        size_t  len;
    } run_t;

    // what each accepted word asked for, matched against results in order
    typedef struct {
        bit    is_alloc;
        size_t len;
    } sent_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [16:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // first_index [15:0], run_length [32:16], zero pad
    logic [0:0]  s_tuser;   // func [0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // alloc_index [15:0], status [17:16], zero pad
    logic        run_done;
    int unsigned mismatches;

    // idling mix of the current phase, in percent
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    // receiver hold-off request, counted down by the ready process
    int          hold_cycles        = 0;

    int unsigned words_sent   = 0;
    int unsigned words_back   = 0;
    int unsigned alloc_sent   = 0;
    int unsigned free_sent    = 0;
    int unsigned nospace_seen = 0;
    int unsigned full_seen    = 0;
    int unsigned caps_written = 0;

    run_t  granted_runs [$];
    sent_t inflight_ops [$];

    first_fit_range_allocator_core #(
        .MAX_RANGES (RANGES),
        .MAX_SLOTS  (SLOTS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ffra_result_checker #(
        .MAX_RANGES (RANGES),
        .MAX_SLOTS  (SLOTS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .run_done   (run_done),
        .mismatches (mismatches)
    );

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // result words: keep the runs handed out so later frees can return them
    always @(posedge aclk) begin : collect
        sent_t op;
        run_t  run;
        if (aresetn && m_tvalid && m_tready) begin
            words_back++;
            if (m_tdata[17:16] == ST_NOSPACE) nospace_seen++;
            if (m_tdata[17:16] == ST_FULL) full_seen++;
            if (inflight_ops.size() != 0) begin
                op = inflight_ops.pop_front();
                // a zero-length grant owns nothing
                if (op.is_alloc && m_tdata[17:16] == ST_OK && op.len != '0) begin
                    run.base = m_tdata[15:0];
                    run.len  = op.len;
                    granted_runs.insert(granted_runs.size(), run);
                end
            end
        end
    end

    // watchdog: ends the run if no word moves on either side for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("first_fit_range_allocator_core regression: fail");
        $finish;
    end

    // offer one request word; entered and left at a falling edge, valid left high
    task automatic send_word(input logic op, input start_t first, input size_t len);
        sent_t rec;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, len, first};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rec.is_alloc = (op == FN_ALLOC);
        rec.len      = len;
        inflight_ops.insert(inflight_ops.size(), rec);
        words_sent++;
        if (op == FN_ALLOC) alloc_sent++;
        else free_sent++;
        @(negedge aclk);
    endtask

    // stop offering and let every outstanding result drain, ends after a rising edge
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (words_back != words_sent) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // new idling mix and a capacity write, only once the block is idle
    task automatic start_phase(input logic [16:0] cap, input int idle_pct,
                               input int stall_pct);
        wait_results_done();
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge aclk);
        cfg_we <= 1'b0;
        granted_runs.delete();
        caps_written++;
    endtask

    // mostly well-formed traffic: allocate small runs, give back runs we hold,
    // with some noise (zero lengths, huge lengths, frees of runs never granted)
    task automatic random_request();
        int   pick;
        int   k;
        run_t run;
        pick = $urandom_range(99);
        if (pick < 45 && granted_runs.size() != 0) begin
            k   = $urandom_range(granted_runs.size() - 1);
            run = granted_runs[k];
            granted_runs.delete(k);
            send_word(FN_FREE, run.base, run.len);
        end else if (pick < 88) begin
            if ($urandom_range(9) == 0)
                send_word(FN_ALLOC, 16'($urandom), 17'($urandom_range(1, 4096)));
            else
                send_word(FN_ALLOC, 16'($urandom), 17'($urandom_range(1, 48)));
        end else begin
            case ($urandom_range(3))
                0: send_word(FN_ALLOC, 16'($urandom), 17'($urandom));
                1: begin
                    if ($urandom_range(3) == 0)
                        send_word(FN_FREE, 16'($urandom), 17'($urandom));
                    else
                        send_word(FN_FREE, 16'($urandom), 17'($urandom_range(1, 64)));
                end
                2: send_word(FN_FREE, 16'($urandom), 17'd0);
                default: send_word(FN_ALLOC, 16'($urandom), 17'd0);
            endcase
        end
    endtask

    task automatic random_run(input int count);
        repeat (count) random_request();
    endtask

    // chop the table into single slots, then free every other one so the
    // range table runs full and the last frees bounce off it
    task automatic fragment_table(input int runs);
        run_t kept [$];
        int   k;
        repeat (runs) send_word(FN_ALLOC, 16'($urandom), 17'd1);
        wait_results_done();
        @(negedge aclk);
        for (k = 0; k < granted_runs.size(); k++) begin
            if (k % 2 == 0)
                send_word(FN_FREE, granted_runs[k].base, granted_runs[k].len);
            else
                kept.insert(kept.size(), granted_runs[k]);
        end
        granted_runs = kept;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        run_done  = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // full index space, no idling, directed corners first
        start_phase(17'h10000, 0, 0);
        send_word(FN_ALLOC, 16'hFFFF, 17'd0);       // zero length gives first start
        send_word(FN_ALLOC, 16'h0000, 17'h10000);   // takes everything, table empties
        send_word(FN_ALLOC, 16'h0000, 17'd1);       // empty table
        send_word(FN_ALLOC, 16'h0000, 17'd0);       // zero length on empty table
        send_word(FN_FREE, 16'h1234, 17'd0);        // freeing nothing
        send_word(FN_FREE, 16'hFFFA, 17'd100);      // reaches past the top index
        send_word(FN_ALLOC, 16'h0000, 17'd10);      // start wraps round to 4
        send_word(FN_ALLOC, 16'h0000, 17'h1FFFF);   // larger than anything held
        send_word(FN_FREE, 16'd100, 17'h1FFFF);     // largest run, touches nothing
        send_word(FN_FREE, 16'd94, 17'd6);          // bridges both sides, size saturates
        send_word(FN_ALLOC, 16'h0000, 17'hFFFF);    // start wraps again
        send_word(FN_FREE, 16'hFFFF, 17'd1);        // top slot on its own
        send_word(FN_ALLOC, 16'h0000, 17'h10000);   // exact fit drops the range
        random_run(150);

        // small capacity, sender idling: fill the range table
        start_phase(17'd200, 52, 0);
        fragment_table(140);
        random_run(100);

        // no capacity at all, then a single slot, receiver stalling
        start_phase(17'd0, 0, 52);
        random_run(20);
        start_phase(17'd1, 0, 52);
        random_run(30);

        // capacity above the slot count, both sides idling, with back-pressure
        start_phase(17'h1FFFF, 36, 36);
        random_run(50);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        hold_cycles = HOLD_OFF_CYCLES;
        @(negedge aclk);
        random_run(50);
        wait_results_done();
        @(negedge aclk);
        random_run(50);

        // some capacity in between
        start_phase(17'($urandom_range(2, SLOTS - 1)), 36, 36);
        random_run(100);

        wait_results_done();
        @(negedge aclk);
        run_done <= 1'b1;
        repeat (2) @(negedge aclk);

        $display("covered %0d request words (%0d allocate, %0d free) under %0d capacities",
                 words_sent, alloc_sent, free_sent, caps_written);
        $display("%0d result words back, %0d without space, %0d with the range table full",
                 words_back, nospace_seen, full_seen);
        if (mismatches == 0)
            $display("first_fit_range_allocator_core regression: pass");
        else
            $display("first_fit_range_allocator_core regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
sv/ffra_pkg.sv
sv/ffra_ctrl.sv
sv/ffra_dp.sv
sv/first_fit_range_allocator_core.sv
test/ffra_tb_pkg.sv
test/ffra_result_checker.sv
test/testbench.sv
